// ===== hw/rtl/eaht_pkg.sv =====
// Package for the edge attribute hash table.
// Holds the opcodes, the read and write selects, and the command and status structs.
// Has no dependencies.
`default_nettype none
package eaht_pkg;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_LOOKUP = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_TAG    = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [11:0] BUCKET_COUNT_RESET = 12'd1024;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_CUR,
        RD_FREE,
        RD_NX
    } t_rd_sel;

    typedef enum logic [3:0] {
        WR_NONE,
        WR_NEW_CUR,
        WR_NEW_FREE,
        WR_LINK_CUR,
        WR_TAG,
        WR_ZERO_CUR,
        WR_COPY_CUR,
        WR_FREE_NX,
        WR_LINK_PREV,
        WR_FREE_CUR,
        WR_CLR
    } t_wr_sel;

    typedef struct packed {
        logic    accept;
        logic    load;
        logic    div_step;
        logic    advance;
        logic    set_hit;
        logic    take_attr;
        logic    set_full;
        logic    clr_start;
        logic    out_load;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
    } t_cmd;

    typedef struct packed {
        logic op_clr;
        logic op_bad;
        logic op_ins;
        logic op_lookup;
        logic op_tag;
        logic div_last;
        logic first;
        logic empty;
        logic match;
        logic lnk_ok;
        logic steps_ok;
        logic free_ok;
        logic prev_valid;
        logic clr_last;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// ===== hw/rtl/eaht_dp.sv =====
// Datapath of the edge attribute hash table: entry memory, hash divider,
// chain walk registers, free list head and output register. Uses eaht_pkg.
`default_nettype none
module eaht_dp #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int VERTEX_BITS   = 24
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  eaht_pkg::t_cmd           i_cmd,
    output eaht_pkg::t_status        o_status,
    input  wire                      i_cfg_valid,
    input  wire [11:0]               i_cfg_bucket_count,
    input  wire [2:0]                i_opcode,
    input  wire [VERTEX_BITS-1:0]    i_vertex_a,
    input  wire [VERTEX_BITS-1:0]    i_vertex_b,
    input  wire signed [31:0]        i_edge_ref,
    input  wire [7:0]                i_edge_tag,
    input  wire                      i_out_stall,
    output logic                     o_out_valid,
    output logic                     o_hit,
    output logic signed [31:0]       o_result_ref,
    output logic [7:0]               o_result_tag,
    output logic                     o_full_res
);
    import eaht_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int LW = AW + 1;
    localparam int VB = VERTEX_BITS;
    localparam int EW = 2 * VB + 40 + LW;
    localparam int HW = VB + 5;
    localparam int CW = $clog2(HW);
    localparam int BW = (LW > 12) ? LW : 12;
    localparam int CLR_B_RESET = (1024 < TABLE_ENTRIES) ? 1024 : TABLE_ENTRIES;

    logic [EW-1:0]   r_mem [TABLE_ENTRIES];
    logic [EW-1:0]   r_rdata;
    logic [EW-1:0]   r_prev_ent;
    logic [11:0]     r_bc;
    logic [2:0]      r_op;
    logic [VB-1:0]   r_lo;
    logic [VB-1:0]   r_hi;
    logic [31:0]     r_ref;
    logic [7:0]      r_tag;
    logic [HW-1:0]   r_div;
    logic [LW-1:0]   r_rem;
    logic [CW-1:0]   r_cnt;
    logic [AW-1:0]   r_cur;
    logic [AW-1:0]   r_prev;
    logic [LW-1:0]   r_nx;
    logic [LW-1:0]   r_steps;
    logic            r_first;
    logic            r_prev_valid;
    logic [LW-1:0]   r_free;
    logic [LW-1:0]   r_clr_b;
    logic [AW-1:0]   r_clr_idx;
    logic            r_hit;
    logic [31:0]     r_res_ref;
    logic [7:0]      r_res_tag;
    logic            r_full;
    logic            r_out_valid;

    logic [BW-1:0]   bc_x;
    logic [LW-1:0]   buckets;
    logic [HW-1:0]   hash;
    logic [LW:0]     div_t;
    logic [LW:0]     div_r;
    logic [VB-1:0]   rd_lo;
    logic [VB-1:0]   rd_hi;
    logic [31:0]     rd_ref;
    logic [7:0]      rd_tag;
    logic [LW-1:0]   rd_link;
    logic            lnk_ok;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [EW-1:0]   wr_data;
    logic [AW-1:0]   rd_addr;
    logic [LW-1:0]   clr_link;

    assign bc_x    = BW'(r_bc);
    assign buckets = (bc_x < BW'(TABLE_ENTRIES)) ? LW'(bc_x) : LW'(TABLE_ENTRIES);
    assign hash    = HW'(7) * HW'(r_lo) + HW'(11) * HW'(r_hi);
    assign div_t   = {r_rem, r_div[HW-1]};
    assign div_r   = (div_t >= {1'b0, buckets}) ? div_t - {1'b0, buckets} : div_t;

    assign rd_lo   = r_rdata[EW-1 -: VB];
    assign rd_hi   = r_rdata[EW-VB-1 -: VB];
    assign rd_ref  = r_rdata[LW+8 +: 32];
    assign rd_tag  = r_rdata[LW +: 8];
    assign rd_link = r_rdata[LW-1:0];
    assign lnk_ok  = (rd_link != '0) && (rd_link < LW'(TABLE_ENTRIES));
    assign clr_link = ({1'b0, r_clr_idx} >= r_clr_b) ? LW'(r_clr_idx) + LW'(1) : '0;

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_cur;
        wr_data = '0;
        case (i_cmd.wr_sel)
            WR_NEW_CUR: begin
                wr_data = {r_lo, r_hi, r_ref, r_tag, {LW{1'b0}}};
            end
            WR_NEW_FREE: begin
                wr_addr = r_free[AW-1:0];
                wr_data = {r_lo, r_hi, r_ref, r_tag, {LW{1'b0}}};
            end
            WR_LINK_CUR: begin
                wr_data = {r_rdata[EW-1:LW], r_free};
            end
            WR_TAG: begin
                wr_data = {rd_lo, rd_hi, r_ref, rd_tag | r_tag, rd_link};
            end
            WR_ZERO_CUR: begin
                wr_data = '0;
            end
            WR_COPY_CUR: begin
                wr_data = r_rdata;
            end
            WR_FREE_NX: begin
                wr_addr = r_nx[AW-1:0];
                wr_data = {{(EW-LW){1'b0}}, r_free};
            end
            WR_LINK_PREV: begin
                wr_addr = r_prev;
                wr_data = {r_prev_ent[EW-1:LW], lnk_ok ? rd_link : {LW{1'b0}}};
            end
            WR_FREE_CUR: begin
                wr_data = {{(EW-LW){1'b0}}, r_free};
            end
            WR_CLR: begin
                wr_addr = r_clr_idx;
                wr_data = {{(EW-LW){1'b0}}, clr_link};
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.rd_sel)
            RD_FREE: rd_addr = r_free[AW-1:0];
            RD_NX:   rd_addr = rd_link[AW-1:0];
            default: rd_addr = r_cur;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_sel != RD_NONE) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_opcode;
            r_lo  <= (i_vertex_a < i_vertex_b) ? i_vertex_a : i_vertex_b;
            r_hi  <= (i_vertex_a < i_vertex_b) ? i_vertex_b : i_vertex_a;
            r_ref <= i_edge_ref;
            r_tag <= i_edge_tag;
        end
        if (i_cmd.load) begin
            r_div        <= hash;
            r_rem        <= '0;
            r_cnt        <= '0;
            r_first      <= 1'b1;
            r_steps      <= '0;
            r_prev_valid <= 1'b0;
            r_hit        <= 1'b0;
            r_res_ref    <= '0;
            r_res_tag    <= '0;
            r_full       <= 1'b0;
        end
        if (i_cmd.div_step) begin
            r_div <= r_div << 1;
            r_rem <= div_r[LW-1:0];
            r_cnt <= r_cnt + CW'(1);
            r_cur <= div_r[AW-1:0];
        end
        if (i_cmd.advance) begin
            r_prev       <= r_cur;
            r_prev_ent   <= r_rdata;
            r_prev_valid <= 1'b1;
            r_cur        <= rd_link[AW-1:0];
            r_steps      <= r_steps + LW'(1);
            r_first      <= 1'b0;
        end
        if (i_cmd.set_hit) begin
            r_hit <= 1'b1;
        end
        if (i_cmd.take_attr) begin
            r_res_ref <= rd_ref;
            r_res_tag <= rd_tag;
        end
        if (i_cmd.set_full) begin
            r_full <= 1'b1;
        end
        if (i_cmd.rd_sel == RD_NX) begin
            r_nx <= rd_link;
        end
        case (i_cmd.wr_sel)
            WR_NEW_FREE: r_free <= (r_free[AW-1:0] == r_cur) ? r_free : rd_link;
            WR_FREE_NX:  r_free <= r_nx;
            WR_FREE_CUR: r_free <= LW'(r_cur);
            WR_CLR:      r_free <= r_clr_b;
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            o_hit        <= r_hit;
            o_result_ref <= r_res_ref;
            o_result_tag <= r_res_tag;
            o_full_res   <= r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc        <= BUCKET_COUNT_RESET;
            r_clr_b     <= LW'(CLR_B_RESET);
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_bc <= i_cfg_bucket_count;
            end
            if (i_cmd.clr_start) begin
                r_clr_b   <= buckets;
                r_clr_idx <= '0;
            end else if (i_cmd.wr_sel == WR_CLR) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_status.op_clr     = (r_op == OP_CLEAR);
        o_status.op_bad     = (r_op > OP_CLEAR) || (buckets == '0) || (r_lo == '0);
        o_status.op_ins     = (r_op == OP_INSERT);
        o_status.op_lookup  = (r_op == OP_LOOKUP);
        o_status.op_tag     = (r_op == OP_TAG);
        o_status.div_last   = (r_cnt == CW'(HW - 1));
        o_status.first      = r_first;
        o_status.empty      = (rd_lo == '0);
        o_status.match      = (rd_lo == r_lo) && (rd_hi == r_hi);
        o_status.lnk_ok     = lnk_ok;
        o_status.steps_ok   = (r_steps < LW'(TABLE_ENTRIES));
        o_status.free_ok    = (r_free != '0) && (r_free < LW'(TABLE_ENTRIES));
        o_status.prev_valid = r_prev_valid;
        o_status.clr_last   = (r_clr_idx == AW'(TABLE_ENTRIES - 1));
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/eaht_ctrl.sv =====
// Controller state machine of the edge attribute hash table.
// Sequences clearing, hashing, chain walks and updates. Uses eaht_pkg.
`default_nettype none
module eaht_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  eaht_pkg::t_status   i_status,
    output eaht_pkg::t_cmd      o_cmd
);
    import eaht_pkg::*;

    typedef enum logic [11:0] {
        S_RST  = 12'b0000_0000_0001,
        S_IDLE = 12'b0000_0000_0010,
        S_LOAD = 12'b0000_0000_0100,
        S_DIV  = 12'b0000_0000_1000,
        S_RD   = 12'b0000_0001_0000,
        S_CHK  = 12'b0000_0010_0000,
        S_AP2  = 12'b0000_0100_0000,
        S_RMA  = 12'b0000_1000_0000,
        S_RMA2 = 12'b0001_0000_0000,
        S_RMB  = 12'b0010_0000_0000,
        S_CLR  = 12'b0100_0000_0000,
        S_DONE = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_RST: begin
                o_cmd.wr_sel = WR_CLR;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                if (i_status.op_clr) begin
                    o_cmd.clr_start = 1'b1;
                    n_state = S_CLR;
                end else if (i_status.op_bad) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_sel = RD_CUR;
                n_state = S_CHK;
            end
            S_CHK: begin
                n_state = S_DONE;
                if (i_status.op_ins) begin
                    if (i_status.first && i_status.empty) begin
                        o_cmd.wr_sel = WR_NEW_CUR;
                    end else if (i_status.match) begin
                        o_cmd.set_hit = 1'b1;
                    end else if (i_status.lnk_ok && i_status.steps_ok) begin
                        o_cmd.advance = 1'b1;
                        n_state = S_RD;
                    end else if (!i_status.free_ok) begin
                        o_cmd.set_full = 1'b1;
                    end else begin
                        o_cmd.wr_sel = WR_LINK_CUR;
                        o_cmd.rd_sel = RD_FREE;
                        n_state = S_AP2;
                    end
                end else if (i_status.first && i_status.empty) begin
                    n_state = S_DONE;
                end else if (i_status.match) begin
                    o_cmd.set_hit = 1'b1;
                    if (i_status.op_lookup) begin
                        o_cmd.take_attr = 1'b1;
                    end else if (i_status.op_tag) begin
                        o_cmd.wr_sel = WR_TAG;
                    end else begin
                        o_cmd.take_attr = 1'b1;
                        if (i_status.prev_valid) begin
                            o_cmd.wr_sel = WR_LINK_PREV;
                            n_state = S_RMB;
                        end else if (!i_status.lnk_ok) begin
                            o_cmd.wr_sel = WR_ZERO_CUR;
                        end else begin
                            o_cmd.rd_sel = RD_NX;
                            n_state = S_RMA;
                        end
                    end
                end else if (i_status.lnk_ok && i_status.steps_ok) begin
                    o_cmd.advance = 1'b1;
                    n_state = S_RD;
                end
            end
            S_AP2: begin
                o_cmd.wr_sel = WR_NEW_FREE;
                n_state = S_DONE;
            end
            S_RMA: begin
                o_cmd.wr_sel = WR_COPY_CUR;
                n_state = S_RMA2;
            end
            S_RMA2: begin
                o_cmd.wr_sel = WR_FREE_NX;
                n_state = S_DONE;
            end
            S_RMB: begin
                o_cmd.wr_sel = WR_FREE_CUR;
                n_state = S_DONE;
            end
            S_CLR: begin
                o_cmd.wr_sel = WR_CLR;
                if (i_status.clr_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_RST;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/edge_attribute_hash_table_unit.sv =====
// Top level of the edge attribute hash table.
// Joins the controller (eaht_ctrl) and the datapath (eaht_dp). Uses eaht_pkg.
//
// Usage: one input transfer carries an opcode and an unordered vertex pair with
// ref and tag; it gives exactly one result transfer. Both channels use valid and
// stall; an item moves when valid is high and stall is low. The bucket count is
// written over its own valid/ready channel, which is always ready; the user must
// write it only while idle; the block does not enforce this. The item is taken
// in (S_IDLE, S_LOAD); S_DIV takes the VERTEX_BITS+5 bit hash modulo the
// bucket count (one quotient bit per cycle in a restoring divider); each chain
// entry is read in S_RD and checked in S_CHK (one entry memory read port); an
// insert or a remove writes memory in S_CHK, S_AP2, S_RMA, S_RMA2 or S_RMB;
// S_DONE loads the result. A clear sweeps the memory at one entry per cycle.
// One item is handled at a time; the input stalls until its result is loaded
// into the output register, which holds while the receiver stalls. After reset,
// the sweep runs before the first item is accepted; bucket count resets to 1024.
`default_nettype none
module edge_attribute_hash_table_unit #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int VERTEX_BITS   = 24
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire [11:0]             i_cfg_bucket_count,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire [2:0]              i_opcode,
    input  wire [VERTEX_BITS-1:0]  i_vertex_a,
    input  wire [VERTEX_BITS-1:0]  i_vertex_b,
    input  wire signed [31:0]      i_edge_ref,
    input  wire [7:0]              i_edge_tag,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output logic                   o_hit,
    output logic signed [31:0]     o_result_ref,
    output logic [7:0]             o_result_tag,
    output logic                   o_full_res
);
    import eaht_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    eaht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    eaht_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .VERTEX_BITS   (VERTEX_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_bucket_count (i_cfg_bucket_count),
        .i_opcode           (i_opcode),
        .i_vertex_a         (i_vertex_a),
        .i_vertex_b         (i_vertex_b),
        .i_edge_ref         (i_edge_ref),
        .i_edge_tag         (i_edge_tag),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_hit              (o_hit),
        .o_result_ref       (o_result_ref),
        .o_result_tag       (o_result_tag),
        .o_full_res         (o_full_res)
    );

endmodule
`default_nettype wire
